>>> rtl/core/x86ex_pkg.sv
// x86ex_pkg: types, opcodes and codes shared by the x86 subset executor.
// Depends on nothing; imported by x86ex_exec and the top level.
package x86ex_pkg;

  // Item kinds on the input channel
  typedef enum logic [1:0] {
    MODE_INSTR  = 2'd0,
    MODE_RDRET  = 2'd1,
    MODE_VECTOR = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  // Result kinds on the output channel
  typedef enum logic [3:0] {
    ACT_NONE     = 4'd0,
    ACT_STACK_WR = 4'd1,
    ACT_STACK_RD = 4'd2,
    ACT_PORT8_IN = 4'd3,
    ACT_PORT16_IN  = 4'd4,
    ACT_PORT8_OUT  = 4'd5,
    ACT_PORT16_OUT = 4'd6,
    ACT_VEC_RD   = 4'd7,
    ACT_HALTED   = 4'd8
  } action_t;

  // Pending read codes; a pop into register r is PEND_POP plus r
  localparam logic [4:0] PEND_NONE = 5'd0;
  localparam logic [4:0] PEND_IN8  = 5'd1;
  localparam logic [4:0] PEND_IN16 = 5'd2;
  localparam logic [4:0] PEND_VEC  = 5'd3;
  localparam logic [4:0] PEND_POP  = 5'd8;

  // Opcode groups that carry a register number in the low three bits
  localparam logic [4:0] GRP_MOV16 = 5'h17;  // 0xB8..0xBF
  localparam logic [4:0] GRP_MOV8  = 5'h16;  // 0xB0..0xB7
  localparam logic [4:0] GRP_PUSH  = 5'h0A;  // 0x50..0x57
  localparam logic [4:0] GRP_POP   = 5'h0B;  // 0x58..0x5F

  // Single opcodes
  localparam logic [7:0] OP_AND8  = 8'h24;
  localparam logic [7:0] OP_AND16 = 8'h25;
  localparam logic [7:0] OP_LOOP  = 8'hE2;
  localparam logic [7:0] OP_IN8   = 8'hE4;
  localparam logic [7:0] OP_IN16  = 8'hE5;
  localparam logic [7:0] OP_OUT8  = 8'hE6;
  localparam logic [7:0] OP_OUT16 = 8'hE7;
  localparam logic [7:0] OP_JMPF  = 8'hEA;
  localparam logic [7:0] OP_HLT   = 8'hF4;
  localparam logic [7:0] OP_CLI   = 8'hFA;
  localparam logic [7:0] OP_STI   = 8'hFB;
  localparam logic [7:0] OP_CLD   = 8'hFC;

  // Register numbers
  localparam logic [2:0] REG_AX = 3'd0;
  localparam logic [2:0] REG_CX = 3'd1;
  localparam logic [2:0] REG_SP = 3'd4;

  // Flag bit positions
  localparam int FL_ZF = 0;
  localparam int FL_SF = 1;
  localparam int FL_IF = 4;
  localparam int FL_DF = 5;

  // Reset values
  localparam logic [15:0] CS_RESET = 16'hF000;
  localparam logic [15:0] SS_RESET = 16'h4000;
  localparam logic [15:0] IP_RESET = 16'hFFF0;

  // Architectural state
  typedef struct packed {
    logic [7:0][15:0] gpr;
    logic [15:0]      cs;
    logic [15:0]      ss;
    logic [15:0]      ip;
    logic [5:0]       flags;
    logic             halted;
    logic [4:0]       pend;
  } arch_state_t;

  // One input item, unpacked
  typedef struct packed {
    mode_t       mode;
    logic [7:0]  opcode;
    logic [15:0] operand_word;
    logic [15:0] segment_word;
    logic [15:0] read_data;
    logic [15:0] read_data_high;
    logic [7:0]  vector_number;
  } in_item_t;

  // One result item
  typedef struct packed {
    action_t     action;
    logic [19:0] address;
    logic [15:0] write_data;
    logic [19:0] next_pc;
    logic [5:0]  flag_bits;
    logic        is_halted;
  } result_t;

  // Segment:offset to 20-bit linear address
  function automatic logic [19:0] lin_addr(logic [15:0] seg, logic [15:0] off);
    lin_addr = {seg, 4'b0000} + {4'b0000, off};
  endfunction

endpackage

>>> rtl/core/x86ex_exec.sv
// x86ex_exec: decode and execute of one item against the architectural state.
// Depends on x86ex_pkg; purely combinational, used by the top level.
module x86ex_exec
  import x86ex_pkg::*;
(
  input  arch_state_t st_i,
  input  in_item_t    item_i,
  output arch_state_t st_o,
  output result_t     res_o
);

  logic [7:0]  imm8;
  logic [15:0] disp;
  logic [15:0] sp;
  logic [15:0] sp_dec;
  logic [15:0] cx_dec;
  logic [7:0]  al_and;
  logic [15:0] ax_and;
  logic [2:0]  rsel;
  logic [1:0]  r8sel;

  assign imm8   = item_i.operand_word[7:0];
  assign disp   = {{8{imm8[7]}}, imm8};
  assign sp     = st_i.gpr[REG_SP];
  assign sp_dec = sp - 16'd2;
  assign cx_dec = st_i.gpr[REG_CX] - 16'd1;
  assign al_and = st_i.gpr[REG_AX][7:0] & imm8;
  assign ax_and = st_i.gpr[REG_AX] & item_i.operand_word;
  assign rsel   = item_i.opcode[2:0];
  assign r8sel  = item_i.opcode[1:0];

  // Next state and request
  always_comb begin
    st_o             = st_i;
    res_o.action     = ACT_NONE;
    res_o.address    = 20'd0;
    res_o.write_data = 16'd0;

    unique case (item_i.mode)
      MODE_INSTR: begin
        if (st_i.halted) begin
          res_o.action = ACT_HALTED;
        end else if (st_i.pend == PEND_NONE) begin
          priority if (item_i.opcode[7:3] == GRP_MOV16) begin
            st_o.gpr[rsel] = item_i.operand_word;
            st_o.ip        = st_i.ip + 16'd3;
          end else if (item_i.opcode[7:3] == GRP_MOV8) begin
            // byte register: bit 2 picks the high half
            if (rsel[2]) begin
              st_o.gpr[{1'b0, r8sel}][15:8] = imm8;
            end else begin
              st_o.gpr[{1'b0, r8sel}][7:0] = imm8;
            end
            st_o.ip = st_i.ip + 16'd2;
          end else if (item_i.opcode[7:3] == GRP_PUSH) begin
            // value taken before SP drops, so PUSH SP stores the old SP
            st_o.ip          = st_i.ip + 16'd1;
            st_o.gpr[REG_SP] = sp_dec;
            res_o.action     = ACT_STACK_WR;
            res_o.address    = lin_addr(st_i.ss, sp_dec);
            res_o.write_data = st_i.gpr[rsel];
          end else if (item_i.opcode[7:3] == GRP_POP) begin
            st_o.ip          = st_i.ip + 16'd1;
            st_o.gpr[REG_SP] = sp + 16'd2;
            st_o.pend        = PEND_POP | {2'b00, rsel};
            res_o.action     = ACT_STACK_RD;
            res_o.address    = lin_addr(st_i.ss, sp);
          end else begin
            unique case (item_i.opcode)
              OP_AND8: begin
                st_o.gpr[REG_AX][7:0] = al_and;
                st_o.flags = {st_i.flags[FL_DF], st_i.flags[FL_IF], 2'b00,
                              al_and[7], (al_and == 8'd0)};
                st_o.ip = st_i.ip + 16'd2;
              end
              OP_AND16: begin
                st_o.gpr[REG_AX] = ax_and;
                st_o.flags = {st_i.flags[FL_DF], st_i.flags[FL_IF], 2'b00,
                              ax_and[15], (ax_and == 16'd0)};
                st_o.ip = st_i.ip + 16'd3;
              end
              OP_LOOP: begin
                st_o.gpr[REG_CX] = cx_dec;
                st_o.ip = (cx_dec != 16'd0) ? (st_i.ip + 16'd2 + disp)
                                            : (st_i.ip + 16'd2);
              end
              OP_IN8: begin
                st_o.ip       = st_i.ip + 16'd2;
                st_o.pend     = PEND_IN8;
                res_o.action  = ACT_PORT8_IN;
                res_o.address = {12'd0, imm8};
              end
              OP_IN16: begin
                st_o.ip       = st_i.ip + 16'd2;
                st_o.pend     = PEND_IN16;
                res_o.action  = ACT_PORT16_IN;
                res_o.address = {12'd0, imm8};
              end
              OP_OUT8: begin
                st_o.ip          = st_i.ip + 16'd2;
                res_o.action     = ACT_PORT8_OUT;
                res_o.address    = {12'd0, imm8};
                res_o.write_data = {8'd0, st_i.gpr[REG_AX][7:0]};
              end
              OP_OUT16: begin
                st_o.ip          = st_i.ip + 16'd2;
                res_o.action     = ACT_PORT16_OUT;
                res_o.address    = {12'd0, imm8};
                res_o.write_data = st_i.gpr[REG_AX];
              end
              OP_JMPF: begin
                st_o.ip = item_i.operand_word;
                st_o.cs = item_i.segment_word;
              end
              OP_CLI: begin
                st_o.flags[FL_IF] = 1'b0;
                st_o.ip = st_i.ip + 16'd1;
              end
              OP_STI: begin
                st_o.flags[FL_IF] = 1'b1;
                st_o.ip = st_i.ip + 16'd1;
              end
              OP_CLD: begin
                st_o.flags[FL_DF] = 1'b0;
                st_o.ip = st_i.ip + 16'd1;
              end
              default: begin
                // HLT and every opcode outside the subset
                st_o.ip      = st_i.ip + 16'd1;
                st_o.halted  = 1'b1;
                res_o.action = ACT_HALTED;
              end
            endcase
          end
        end
      end

      MODE_RDRET: begin
        // complete whatever read is outstanding, then clear it
        priority if (st_i.pend[4:3] == PEND_POP[4:3]) begin
          st_o.gpr[st_i.pend[2:0]] = item_i.read_data;
        end else if (st_i.pend == PEND_IN8) begin
          st_o.gpr[REG_AX][7:0] = item_i.read_data[7:0];
        end else if (st_i.pend == PEND_IN16) begin
          st_o.gpr[REG_AX] = item_i.read_data;
        end else if (st_i.pend == PEND_VEC) begin
          st_o.ip = item_i.read_data;
          st_o.cs = item_i.read_data_high;
        end else begin
          st_o.pend = PEND_NONE;
        end
        st_o.pend = PEND_NONE;
      end

      MODE_VECTOR: begin
        if (st_i.pend == PEND_NONE) begin
          st_o.pend        = PEND_VEC;
          res_o.action     = ACT_VEC_RD;
          res_o.address    = {10'd0, item_i.vector_number, 2'b00};
          res_o.write_data = sp;
        end
      end

      default: begin
        st_o = st_i;
      end
    endcase

    res_o.next_pc   = lin_addr(st_o.cs, st_o.ip);
    res_o.flag_bits = st_o.flags;
    res_o.is_halted = st_o.halted;
  end

endmodule

>>> rtl/core/x86_subset_instruction_executor_top.sv
// x86_subset_instruction_executor_top: stream wrapper, state and result registers.
// Depends on x86ex_pkg and x86ex_exec.
//
// Usage: each input item is an instruction (tuser 0), a read return (1) or an
// interrupt vector entry (2). Every accepted item yields exactly one result item
// carrying the bus or port request kind in out_tuser and the address, write data,
// next linear PC, flags and halt mark in out_tdata.
// Path: an item is captured in the input register, executes against the
// architectural registers once the result slot is free or draining, and lands
// in the result register, which drives out_tvalid.
// Throughput: one item per cycle while out_tready is high; the execute path reads
// and writes the architectural registers in the same cycle.
// POP, IN and vector entry return a read request; the next read return item
// completes it. A halted core answers instructions with the halted action.
// Reset: synchronous, active low; CS:IP = F000:FFF0, SS = 4000, all other architectural state zero.
// Stall: when out_tready is low the result holds, one more item waits in the
// input register, and in_tready drops only while both are full.
module x86_subset_instruction_executor_top
  import x86ex_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // opcode[7:0], operand_word[23:8], segment_word[39:24], read_data[55:40],
  // read_data_high[71:56], vector_number[79:72]
  input  logic [79:0] in_tdata,
  input  logic [1:0]  in_tuser,   // mode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  // address[19:0], write_data[35:20], next_pc[55:36], flag_bits[61:56],
  // is_halted[62], zero[63]
  output logic [63:0] out_tdata,
  output logic [3:0]  out_tuser   // action[3:0]
);

  logic        s1_valid_r;
  in_item_t    s1_item_r;
  arch_state_t state_r;
  arch_state_t state_nxt;
  result_t     res;
  logic        out_valid_r;
  logic [63:0] out_data_r;
  action_t     out_act_r;
  logic        advance;

  // Handshake: execute when the result slot is free or being drained
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_item_r.mode           <= mode_t'(in_tuser);
      s1_item_r.opcode         <= in_tdata[7:0];
      s1_item_r.operand_word   <= in_tdata[23:8];
      s1_item_r.segment_word   <= in_tdata[39:24];
      s1_item_r.read_data      <= in_tdata[55:40];
      s1_item_r.read_data_high <= in_tdata[71:56];
      s1_item_r.vector_number  <= in_tdata[79:72];
    end
  end

  // Execute
  x86ex_exec u_exec (
    .st_i   (state_r),
    .item_i (s1_item_r),
    .st_o   (state_nxt),
    .res_o  (res)
  );

  // Architectural registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.gpr    <= '0;
      state_r.cs     <= CS_RESET;
      state_r.ss     <= SS_RESET;
      state_r.ip     <= IP_RESET;
      state_r.flags  <= '0;
      state_r.halted <= 1'b0;
      state_r.pend   <= PEND_NONE;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_act_r  <= res.action;
      out_data_r <= {1'b0, res.is_halted, res.flag_bits, res.next_pc,
                     res.write_data, res.address};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_act_r;

  // Halt mark never clears once set
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.halted |=> state_r.halted)
    else $error("halt mark cleared");

  // Architectural state moves only when an item executes
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(state_r))
    else $error("state changed without an executed item");

  // An instruction on a halted core reports the halted action
  a_halt_answer: assert property (@(posedge clk) disable iff (!rst_n)
    advance && state_r.halted && s1_item_r.mode == MODE_INSTR
    |=> out_tuser == ACT_HALTED)
    else $error("halted core did not report halt");

  // A stack read request leaves a pop pending
  a_pop_pending: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res.action == ACT_STACK_RD |=> state_r.pend[4:3] == PEND_POP[4:3])
    else $error("pop issued without pending read");

endmodule
